// ===== rtl/led_status_animator_defines.svh =====
// Assertion macros shared by the LED status animator RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef LED_STATUS_ANIMATOR_DEFINES_SVH
`define LED_STATUS_ANIMATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define LSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define LSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/lsa_pkg.sv =====
// Types, register indexes and constants of the LED status animator.
// Used by lsa_core, lsa_out_buf and led_status_animator; depends on nothing.
package lsa_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int RES_SLOTS  = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_IDLE_PERIOD    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ALARM_PERIOD   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REFRESH_PERIOD = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_IDLE_HUE       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LED_COUNT      = 3'd4;

  localparam logic [15:0] RST_IDLE_PERIOD    = 16'd500;
  localparam logic [15:0] RST_ALARM_PERIOD   = 16'd200;
  localparam logic [15:0] RST_REFRESH_PERIOD = 16'd100;
  localparam logic [7:0]  RST_IDLE_HUE       = 8'd12;
  localparam logic [7:0]  RST_LED_COUNT      = 8'd88;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_POLL = 1'b1;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_RANGE_A = 2'd1;
  localparam logic [1:0] MODE_RANGE_B = 2'd2;

  localparam logic KIND_COLOR  = 1'b0;
  localparam logic KIND_STROBE = 1'b1;

  localparam logic [15:0] RANGE_MIN  = 16'd40;
  localparam logic [15:0] RANGE_MAX  = 16'd400;
  localparam logic [7:0]  HUE_SPAN   = 8'd80;
  localparam logic [7:0]  DARK_HUE   = 8'd255;
  localparam logic [7:0]  RED_HUE    = 8'd0;
  localparam logic [7:0]  FULL_VALUE = 8'd255;
  localparam logic [7:0]  DARK_VALUE = 8'd0;

  // floor(x/9) for x up to 720 equals (x * 911) >> 13.
  localparam logic [9:0] DIV9_MULT  = 10'd911;
  localparam int         DIV9_SHIFT = 13;

  typedef struct packed {
    logic       kind;
    logic [7:0] hue;
    logic [7:0] brightness;
  } lsa_res_t;

  typedef struct packed {
    lsa_res_t [RES_SLOTS-1:0] item;
    logic [1:0]               count;
  } lsa_bundle_t;

  // Hue for a range of at least RANGE_MIN: (range-40)*80/360, held at 80 above 400.
  function automatic logic [7:0] range_hue(input logic [15:0] range_value);
    logic [8:0]  span_off;
    logic [19:0] prod;
    logic [7:0]  hue;
    span_off = 9'(range_value - RANGE_MIN);
    prod     = 20'({span_off, 1'b0}) * 20'(DIV9_MULT);
    if (range_value > RANGE_MAX) begin
      hue = HUE_SPAN;
    end else begin
      hue = 8'(prod >> DIV9_SHIFT);
    end
    return hue;
  endfunction

endpackage

// ===== rtl/led_status_animator.sv =====
// LED status animator top level. A beat is taken whenever the result buffer is
// empty or is sending its final pending beat; a tick beat can follow every cycle
// while the buffer is empty. A poll beat yields zero to three results; the first
// appears in the cycle after the poll is taken and the rest follow one per cycle
// while the output is ready. Synchronous active-low reset zeroes counters,
// phases and alarm, restores register defaults and empties the result buffer.
module led_status_animator #(
  parameter int TICK_COUNTER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lsa_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lsa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // mode [1:0], range_value [17:2], zero [23:18]
  input  logic [0:0]                      in_tuser,   // opcode [0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // hue [7:0], brightness [15:8]
  output logic [0:0]                      out_tuser,  // kind [0]
  output logic                            out_tlast
);
  import lsa_pkg::*;

  logic        accept, push, can_load;
  lsa_bundle_t bundle;

  assign in_tready = can_load;
  assign accept    = in_tvalid && can_load;

  lsa_core #(
    .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .opcode      (in_tuser[0]),
    .mode        (in_tdata[1:0]),
    .range_value (in_tdata[17:2]),
    .push        (push),
    .bundle      (bundle)
  );

  lsa_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .bundle     (bundle),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/lsa_core.sv =====
// Configuration registers, tick counters and blink state of the animator.
// Decides the results of each poll beat. Depends on lsa_pkg and the defines header.
`include "led_status_animator_defines.svh"

module lsa_core #(
  parameter int TICK_COUNTER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lsa_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lsa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            accept,
  input  logic                            opcode,
  input  logic [1:0]                      mode,
  input  logic [15:0]                     range_value,
  output logic                            push,
  output lsa_pkg::lsa_bundle_t            bundle
);
  import lsa_pkg::*;

  localparam int CMP_W = (TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16;

  logic [15:0] idle_period_r, alarm_period_r, refresh_period_r;
  logic [7:0]  idle_hue_r, led_count_r;

  logic [TICK_COUNTER_BITS-1:0] idle_ticks_r, alarm_ticks_r, refresh_ticks_r;
  logic [TICK_COUNTER_BITS-1:0] idle_ticks_nxt, alarm_ticks_nxt, refresh_ticks_nxt;
  logic idle_phase_r, alarm_phase_r, alarm_en_r;
  logic idle_phase_nxt, alarm_phase_nxt, alarm_en_nxt;

  logic is_poll, ranging, near;
  logic idle_fire, alarm_fire, ref_fire, color_fire;
  lsa_bundle_t bundle_c;

  assign is_poll = accept && (opcode == OP_POLL);
  assign ranging = (mode == MODE_RANGE_A) || (mode == MODE_RANGE_B);
  assign near    = range_value < RANGE_MIN;

  assign idle_fire  = (mode == MODE_IDLE) &&
                      (CMP_W'(idle_ticks_r) > CMP_W'(idle_period_r));
  assign alarm_fire = alarm_en_r && ranging &&
                      (CMP_W'(alarm_ticks_r) > CMP_W'(alarm_period_r));
  assign ref_fire   = CMP_W'(refresh_ticks_r) > CMP_W'(refresh_period_r);
  assign color_fire = ref_fire && ranging && !near;

  // Results are packed in step order: blink, range color, then the strobe.
  // Idle and alarm blinks never fire together, so one blink slot suffices.
  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    bundle_c = '0;
    if (idle_fire) begin
      bundle_c.item[n].kind       = KIND_COLOR;
      bundle_c.item[n].hue        = idle_phase_r ? DARK_HUE : idle_hue_r;
      bundle_c.item[n].brightness = idle_phase_r ? DARK_VALUE : FULL_VALUE;
      n = n + 2'd1;
    end else if (alarm_fire) begin
      bundle_c.item[n].kind       = KIND_COLOR;
      bundle_c.item[n].hue        = alarm_phase_r ? DARK_HUE : RED_HUE;
      bundle_c.item[n].brightness = alarm_phase_r ? DARK_VALUE : FULL_VALUE;
      n = n + 2'd1;
    end
    if (color_fire) begin
      bundle_c.item[n].kind       = KIND_COLOR;
      bundle_c.item[n].hue        = range_hue(range_value);
      bundle_c.item[n].brightness = FULL_VALUE;
      n = n + 2'd1;
    end
    if (ref_fire) begin
      bundle_c.item[n].kind       = KIND_STROBE;
      bundle_c.item[n].hue        = 8'd0;
      bundle_c.item[n].brightness = DARK_VALUE;
      n = n + 2'd1;
    end
    bundle_c.count = n;
  end

  assign push   = is_poll && (bundle_c.count != 2'd0);
  assign bundle = bundle_c;

  always_comb begin
    idle_ticks_nxt    = idle_ticks_r;
    alarm_ticks_nxt   = alarm_ticks_r;
    refresh_ticks_nxt = refresh_ticks_r;
    idle_phase_nxt    = idle_phase_r;
    alarm_phase_nxt   = alarm_phase_r;
    alarm_en_nxt      = alarm_en_r;
    if (accept && (opcode == OP_TICK)) begin
      idle_ticks_nxt    = idle_ticks_r + 1'b1;
      alarm_ticks_nxt   = alarm_ticks_r + 1'b1;
      refresh_ticks_nxt = refresh_ticks_r + 1'b1;
    end else if (is_poll) begin
      if (idle_fire) begin
        idle_phase_nxt = !idle_phase_r;
        idle_ticks_nxt = '0;
      end
      if (alarm_fire) begin
        alarm_phase_nxt = !alarm_phase_r;
        alarm_ticks_nxt = '0;
      end
      if (ref_fire) begin
        refresh_ticks_nxt = '0;
        if (ranging) begin
          alarm_en_nxt = near;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_ticks_r    <= '0;
      alarm_ticks_r   <= '0;
      refresh_ticks_r <= '0;
      idle_phase_r    <= 1'b0;
      alarm_phase_r   <= 1'b0;
      alarm_en_r      <= 1'b0;
    end else begin
      idle_ticks_r    <= idle_ticks_nxt;
      alarm_ticks_r   <= alarm_ticks_nxt;
      refresh_ticks_r <= refresh_ticks_nxt;
      idle_phase_r    <= idle_phase_nxt;
      alarm_phase_r   <= alarm_phase_nxt;
      alarm_en_r      <= alarm_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_period_r    <= RST_IDLE_PERIOD;
      alarm_period_r   <= RST_ALARM_PERIOD;
      refresh_period_r <= RST_REFRESH_PERIOD;
      idle_hue_r       <= RST_IDLE_HUE;
      led_count_r      <= RST_LED_COUNT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IDLE_PERIOD:    idle_period_r    <= cfg_wdata;
        REG_ALARM_PERIOD:   alarm_period_r   <= cfg_wdata;
        REG_REFRESH_PERIOD: refresh_period_r <= cfg_wdata;
        REG_IDLE_HUE:       idle_hue_r       <= cfg_wdata[7:0];
        REG_LED_COUNT:      led_count_r      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  `LSA_ASSERT_NEXT(a_refresh_clears, clk, rst_n, is_poll && ref_fire,
                   refresh_ticks_r == '0, "refresh did not clear its counter")
  `LSA_ASSERT_NOW(a_blink_exclusive, clk, rst_n, is_poll,
                  !(idle_fire && alarm_fire), "idle and alarm blink fired together")
  `LSA_ASSERT_NEXT(a_led_count_write, clk, rst_n,
                   cfg_we && (cfg_addr == REG_LED_COUNT),
                   led_count_r == $past(cfg_wdata[7:0]), "LED count write lost")

endmodule

// ===== rtl/lsa_out_buf.sv =====
// Result buffer of the animator: holds the results of one poll and sends them one beat per
// cycle unless stalled, marking the final one. Depends on lsa_pkg and the defines header.
`include "led_status_animator_defines.svh"

module lsa_out_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lsa_pkg::lsa_bundle_t  bundle,
  output logic                  can_load,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,   // hue [7:0], brightness [15:8]
  output logic [0:0]            out_tuser,   // kind [0]
  output logic                  out_tlast
);
  import lsa_pkg::*;

  lsa_res_t [RES_SLOTS-1:0] slot_r, slot_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       fire;

  assign out_tvalid = cnt_r != 2'd0;
  assign fire       = out_tvalid && out_tready;
  // A new poll may load while the last pending beat leaves.
  assign can_load   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);

  assign out_tdata = {slot_r[0].brightness, slot_r[0].hue};
  assign out_tuser = slot_r[0].kind;
  assign out_tlast = cnt_r == 2'd1;

  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      slot_nxt = bundle.item;
      cnt_nxt  = bundle.count;
    end else if (fire) begin
      slot_nxt[0] = slot_r[1];
      slot_nxt[1] = slot_r[2];
      cnt_nxt     = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  `LSA_ASSERT_NOW(a_load_when_free, clk, rst_n, push, can_load,
                  "results loaded over pending beats")
  `LSA_ASSERT_NOW(a_push_nonempty, clk, rst_n, push, bundle.count != 2'd0,
                  "empty result set loaded")
  `LSA_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, cnt_r != 2'd3 || !fire || !push,
                  "load while three beats pending")

endmodule
